// ===== sv/cbp_pkg.sv =====
// Shared constants, types and the counter update function of the correlating branch predictor.
package cbp_pkg;

    localparam int INDEX_BITS  = 12;
    localparam int HIST_BITS   = 2;
    localparam int ADDR_BITS   = INDEX_BITS + HIST_BITS;
    localparam int TABLE_DEPTH = 1 << ADDR_BITS;
    localparam int PC_BITS     = 32;

    typedef logic [1:0]           counter_t;
    typedef logic [ADDR_BITS-1:0] tbl_addr_t;
    typedef logic [HIST_BITS-1:0] hist_t;

    localparam counter_t COUNTER_RESET = 2'd3;
    localparam hist_t    HIST_RESET    = HIST_BITS'(3);

    // One write into the counter table.
    typedef struct packed {
        logic      en;
        tbl_addr_t addr;
        counter_t  data;
    } tbl_wr_t;

    // Two-bit saturating counter with the jump from a weak state to the opposite strong state on a miss.
    function automatic counter_t next_counter(input counter_t c, input logic taken);
        counter_t n;
        n = c;
        case (c)
            2'd0:    n = taken ? 2'd1 : 2'd0;
            2'd1:    n = taken ? 2'd3 : 2'd0;
            2'd2:    n = taken ? 2'd3 : 2'd0;
            2'd3:    n = taken ? 2'd3 : 2'd2;
            default: n = c;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/cbp_table.sv =====
// Counter table: one write port and one read port with registered read data.
module cbp_table
    import cbp_pkg::*;
(
    input  logic      clk,
    input  tbl_wr_t   wr,
    input  logic      rd_en,
    input  tbl_addr_t rd_addr,
    output counter_t  rd_data
);

    counter_t mem [TABLE_DEPTH];
    counter_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read during a write to the same entry returns the old value.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/correlating_branch_predictor_core.sv =====
// Top level of the correlating branch predictor: control, history, forwarding and output register.
//
//   channel   valid          stall          payload
//   branch    branch_valid   branch_stall   branch_pc[31:0], was_taken
//   pred      pred_valid     pred_stall     predict_taken
//
// A branch transfer is accepted every cycle when the output side keeps up; the
// table is read and the branch registered in the update stage at the transfer edge,
// and the prediction is registered, together with the counter write-back, once the output register is free.
// The table read-modify-write is split over the read and the update stage, with one-deep forwarding of the
// counter written in the same cycle as the next read of that entry.
// After reset the table is swept to strongly taken, one entry per cycle, over
// all 16384 entries; branch_stall stays high during the sweep.
// A held pred transfer stalls the update stage, and then the branch channel.
module correlating_branch_predictor_core
    import cbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               branch_valid,
    output logic               branch_stall,
    input  logic [PC_BITS-1:0] branch_pc,
    input  logic               was_taken,
    output logic               pred_valid,
    input  logic               pred_stall,
    output logic               predict_taken
);

    logic [ADDR_BITS:0] clear_cnt_reg, clear_cnt_next;
    hist_t              hist_reg, hist_next;
    logic               s1_valid_reg, s1_valid_next;
    tbl_addr_t          s1_addr_reg, s1_addr_next;
    logic               s1_taken_reg, s1_taken_next;
    logic               fwd_hit_reg, fwd_hit_next;
    counter_t           fwd_val_reg, fwd_val_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_pred_reg, out_pred_next;

    logic      clearing;
    logic      out_free;
    logic      s1_go;
    logic      accept;
    tbl_addr_t in_addr;
    counter_t  rd_data;
    counter_t  s1_cur;
    counter_t  s1_new;
    tbl_wr_t   wr;

    assign clearing = !clear_cnt_reg[ADDR_BITS];
    assign out_free = !out_valid_reg || !pred_stall;
    assign s1_go    = s1_valid_reg && out_free;

    assign branch_stall = clearing || (s1_valid_reg && !out_free);
    assign accept       = branch_valid && !branch_stall;

    assign in_addr = {branch_pc[INDEX_BITS-1:0], hist_reg};

    // The counter written at the edge of this item's read is not in the read data.
    assign s1_cur = fwd_hit_reg ? fwd_val_reg : rd_data;
    assign s1_new = next_counter(s1_cur, s1_taken_reg);

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = s1_addr_reg;
        wr.data = s1_new;
        if (clearing)
        begin
            wr.en   = 1'b1;
            wr.addr = clear_cnt_reg[ADDR_BITS-1:0];
            wr.data = COUNTER_RESET;
        end
        else if (s1_go)
        begin
            wr.en = 1'b1;
        end
    end

    cbp_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        hist_next      = hist_reg;
        s1_valid_next  = s1_valid_reg;
        s1_addr_next   = s1_addr_reg;
        s1_taken_next  = s1_taken_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_val_next   = fwd_val_reg;
        out_valid_next = out_valid_reg;
        out_pred_next  = out_pred_reg;

        if (clearing)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
        end

        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_pred_next = s1_cur[1];
            end
        end

        if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_addr_next  = in_addr;
            s1_taken_next = was_taken;
            fwd_hit_next  = s1_valid_reg && (s1_addr_reg == in_addr);
            fwd_val_next  = s1_new;
            hist_next     = (hist_reg >> 1) | (HIST_BITS'(was_taken) << (HIST_BITS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            hist_reg      <= HIST_RESET;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            hist_reg      <= hist_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        s1_taken_reg <= s1_taken_next;
        fwd_val_reg  <= fwd_val_next;
        out_pred_reg <= out_pred_next;
    end

    assign pred_valid    = out_valid_reg;
    assign predict_taken = out_pred_reg;

    // No branch may enter while the table is still being swept.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> branch_stall)
        else $error("branch accepted during table sweep");

    // An item leaving the update stage always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) s1_go |=> pred_valid)
        else $error("update stage result lost");

    // A read of the entry being written in the same cycle must take the forwarded value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && (s1_addr_reg == in_addr)) |=> fwd_hit_reg)
        else $error("missing forward on same-entry read");

endmodule

// ===== tb/cbp_prediction_checker.sv =====
// Checker for the correlating branch predictor: shadows counters and history and checks predictions.
module cbp_prediction_checker
    import cbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               branch_valid,
    input  logic               branch_stall,
    input  logic [PC_BITS-1:0] branch_pc,
    input  logic               was_taken,
    input  logic               pred_valid,
    input  logic               pred_stall,
    input  logic               predict_taken,
    output int                 fails,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    counter_t shadow_ctr [TABLE_DEPTH];
    hist_t    shadow_hist;
    logic     expected_dirs [$];
    logic     exp_dir;
    int       preds_seen;

    function automatic counter_t trained_counter(input counter_t c, input logic taken);
        if (taken)
            return (c == 2'd0) ? 2'd1 : 2'd3;
        return (c == 2'd3) ? 2'd2 : 2'd0;
    endfunction

    // Reads the direction for one branch, then trains the shadow counter and history with it.
    function automatic logic direction_for(input logic [PC_BITS-1:0] pc, input logic taken);
        tbl_addr_t idx;
        counter_t  c;
        idx = {pc[INDEX_BITS-1:0], shadow_hist};
        c = shadow_ctr[idx];
        shadow_ctr[idx] = trained_counter(c, taken);
        shadow_hist = (shadow_hist >> 1) | (hist_t'(taken) << (HIST_BITS - 1));
        return c[1];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        outstanding = 0;
        preds_seen = 0;
    end

    // Inputs change only at the rising edge, so the falling edge sees what the next edge accepts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            foreach (shadow_ctr[j])
                shadow_ctr[j] = COUNTER_RESET;
            shadow_hist = HIST_RESET;
            expected_dirs.delete();
        end
        else
        begin
            if (branch_valid && !branch_stall)
                expected_dirs.push_back(direction_for(branch_pc, was_taken));
            if (pred_valid && !pred_stall)
            begin
                preds_seen++;
                if (expected_dirs.size() == 0)
                    report_mismatch($sformatf("prediction %0d arrived with none pending",
                                              preds_seen));
                else
                begin
                    exp_dir = expected_dirs.pop_front();
                    if (predict_taken !== exp_dir)
                        report_mismatch($sformatf("prediction %0d: predict_taken %b, expected %b",
                                                  preds_seen, predict_taken, exp_dir));
                end
            end
        end
        outstanding = expected_dirs.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the correlating branch predictor: clock, reset, branch stimulus and verdict.
module tb_top
    import cbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_ITEMS   = 48;
    localparam int LONG_HOLD    = 60;
    localparam int PAUSE_AT     = 900;
    localparam int QUIET_AT     = 1550;
    localparam int HOT_ROWS     = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               branch_valid;
    logic               branch_stall;
    logic [PC_BITS-1:0] branch_pc;
    logic               was_taken;
    logic               pred_valid;
    logic               pred_stall;
    logic               predict_taken;
    int                 fails;
    int                 outstanding;
    int                 holds_asked = 0;
    int                 holds_done = 0;
    logic               quiet_tail = 1'b0;

    always #5 clk = ~clk;

    correlating_branch_predictor_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .branch_valid  (branch_valid),
        .branch_stall  (branch_stall),
        .branch_pc     (branch_pc),
        .was_taken     (was_taken),
        .pred_valid    (pred_valid),
        .pred_stall    (pred_stall),
        .predict_taken (predict_taken)
    );

    cbp_prediction_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .branch_valid  (branch_valid),
        .branch_stall  (branch_stall),
        .branch_pc     (branch_pc),
        .was_taken     (was_taken),
        .pred_valid    (pred_valid),
        .pred_stall    (pred_stall),
        .predict_taken (predict_taken),
        .fails         (fails),
        .outstanding   (outstanding)
    );

    // Offers one branch and returns at the edge where the transfer happens.
    task automatic send_branch(input logic [PC_BITS-1:0] pc, input logic taken);
        logic go;
        branch_valid <= 1'b1;
        branch_pc    <= pc;
        was_taken    <= taken;
        do
        begin
            @(negedge clk);
            go = !branch_stall;
            @(posedge clk);
        end
        while (!go);
    endtask

    // Prediction side: short random stalls, quiet stretches, and the long hold on request.
    initial
    begin
        int cyc;
        int n;
        cyc = 0;
        pred_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (holds_done != holds_asked)
            begin
                pred_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                pred_stall <= 1'b0;
            end
            else if (!quiet_tail && ((cyc / 64) % 3 != 0) && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 3);
                pred_stall <= 1'b1;
                repeat (n) @(posedge clk);
                pred_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                  i;
        int                  k;
        int                  sel;
        logic [PC_BITS-1:0]  pc;
        logic [PC_BITS-1:0]  last_pc;
        logic                tk;
        logic                last_tk;
        logic [INDEX_BITS-1:0] hot_row [HOT_ROWS];
        logic                hot_last [HOT_ROWS];

        rst_n        <= 1'b0;
        branch_valid <= 1'b0;
        branch_pc    <= '0;
        was_taken    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero address, all-ones address, and upper bits that alias onto row zero.
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'h0000_0FFF, 1'b1);
        send_branch(32'hFFFF_F000, 1'b0);
        send_branch(32'h0000_0000, 1'b0);
        // Walk the counters down to zero and back up, back to back on the same rows.
        repeat (6) send_branch(32'h0000_0040, 1'b0);
        repeat (6) send_branch(32'h0000_0040, 1'b1);
        for (i = 0; i < 4; i++)
            send_branch(32'h1234_5040, i[0]);

        foreach (hot_row[j])
        begin
            hot_row[j]  = INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
            hot_last[j] = 1'b0;
        end
        last_pc = '0;
        last_tk = 1'b0;

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                holds_asked++;
            if (i == PAUSE_AT)
            begin
                branch_valid <= 1'b0;
                wait (outstanding == 0);
                @(posedge clk);
            end
            if (i == QUIET_AT)
                quiet_tail = 1'b1;

            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                // Same row and outcome again, so the same table row is hit back to back.
                pc = last_pc;
                tk = last_tk;
            end
            else if (sel < 30)
            begin
                pc = $urandom;
                tk = 1'($urandom_range(0, 1));
            end
            else
            begin
                k = $urandom_range(0, HOT_ROWS - 1);
                pc = $urandom;
                pc[INDEX_BITS-1:0] = hot_row[k];
                case (k % 4)
                    0:       tk = ($urandom_range(0, 19) != 0);
                    1:       tk = ($urandom_range(0, 19) == 0);
                    2:       tk = ~hot_last[k];
                    default: tk = ($urandom_range(0, 9) < 7);
                endcase
                hot_last[k] = tk;
            end
            last_pc = pc;
            last_tk = tk;
            send_branch(pc, tk);

            if (!quiet_tail && (i < HOLD_AT || i >= HOLD_AT + HOLD_ITEMS)
                && ((i / 80) % 3 != 1) && $urandom_range(0, 4) == 0)
            begin
                branch_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end

        branch_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cbp_pkg.sv
sv/cbp_table.sv
sv/correlating_branch_predictor_core.sv
tb/cbp_prediction_checker.sv
tb/tb_top.sv
